FILE: rtl/serial_frame_extractor_assert.svh
// Assertion macros for the serial frame extractor.
`ifndef SERIAL_FRAME_EXTRACTOR_ASSERT_SVH
`define SERIAL_FRAME_EXTRACTOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk_i, ignored while in reset
`define SFE_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("serial_frame_extractor: check failed");
// Next-cycle implication, sampled on clk_i, ignored while in reset
`define SFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("serial_frame_extractor: check failed");
`else
`define SFE_ASSERT_IMPLIES(lbl, ante, cons)
`define SFE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/sfe_pkg.sv
// Shared types and constants of the serial frame extractor.
package sfe_pkg;

  // Input operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] CFG_HDR_LO   = 3'd0;
  localparam logic [2:0] CFG_HDR_HI   = 3'd1;
  localparam logic [2:0] CFG_DELIM    = 3'd2;
  localparam logic [2:0] CFG_DCOUNT   = 3'd3;
  localparam logic [2:0] CFG_TBASE    = 3'd4;
  localparam logic [2:0] CFG_TPERBYTE = 3'd5;

  // Configuration reset values
  localparam logic [31:0] DELIM_RST    = 32'd10;
  localparam logic [2:0]  DCOUNT_RST   = 3'd1;
  localparam logic [15:0] TBASE_RST    = 16'd100;
  localparam logic [7:0]  TPERBYTE_RST = 8'd2;

  // Pattern byte marking a length nibble
  localparam logic [7:0] NIBBLE_MARK = 8'h0F;
  // Bytes held by the pattern registers
  localparam int PAT_BYTES = 9;
  // Longest delimiter sequence
  localparam int DELIM_MAX = 4;
  // Tick counter width: longest limit is 63 * 255 + 65535
  localparam int TICK_W = 17;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
    logic       framed_by_length;
    logic       empty_frame;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic wr_byte;     // store byte, shift history, bump fill count
    logic hdr_take;    // valid header: clear buffer, maybe enter counted mode
    logic cnt_emit;    // counted frame complete: latch length, leave counted mode
    logic dlm_emit;    // delimiter frame complete: latch length, clear buffer
    logic emit_empty;  // load the empty-frame result
    logic tick_mul;    // latch expected length times per-byte ticks
    logic tick_upd;    // count a tick, drop frame on timeout
    logic rd_en;       // read buffer at readout index
    logic out_load;    // load result register from buffer data
    logic rd_next;     // advance readout index
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic counted;
    logic fill_eq_exp;
    logic hdr_valid;
    logic delim_hit;
    logic delim_empty;
    logic out_last;
  } dp_status_t;

endpackage

FILE: rtl/sfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/sfe_datapath.sv
// Datapath of the serial frame extractor: config, buffer, header and delimiter match.
module sfe_datapath #(
  parameter int BUFFER_BYTES = 64,
  parameter int HEADER_BYTES = 9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [63:0]           cfg_data_i,
  input  logic [7:0]            rx_byte_i,
  input  sfe_pkg::dp_cmd_t      cmd_i,
  output sfe_pkg::dp_status_t   status_o,
  output sfe_pkg::out_item_t    out_o
);
  import sfe_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int HIST_BYTES = (HEADER_BYTES > DELIM_MAX) ? HEADER_BYTES : DELIM_MAX;
  localparam int PW = AW + 8;

  // Configuration registers
  logic [63:0] hdr_lo_q;
  logic [7:0]  hdr_hi_q;
  logic [31:0] delim_q;
  logic [2:0]  dcount_q;
  logic [15:0] tbase_q;
  logic [7:0]  tper_q;

  // Frame control state
  logic [AW-1:0]     fill_q, fill_d;
  logic [AW-1:0]     exp_q, exp_d;
  logic [TICK_W-1:0] elapsed_q, elapsed_d;

  // Payload state
  logic [7:0]    hist_q [HIST_BYTES];
  logic [PW-1:0] prod_q;
  logic [AW-1:0] count_q;
  logic [AW-1:0] rd_idx_q;
  logic          by_len_q;
  out_item_t     out_q;

  logic [7:0]        ram_rdata;
  logic [7:0]        pat [PAT_BYTES];
  logic [7:0]        tail [DELIM_MAX];
  logic              hdr_match;
  logic [15:0]       hdr_len;
  logic              hdr_valid;
  logic              hdr_fits;
  logic [2:0]        dc;
  logic [1:0]        didx;
  logic              delim_match;
  logic              delim_hit;
  logic [AW-1:0]     start;
  logic [AW-1:0]     fill_inc;
  logic [TICK_W-1:0] elapsed_inc;
  logic [TICK_W-1:0] limit;
  logic              rd_last;

  // Configuration write decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_lo_q <= '0;
      hdr_hi_q <= '0;
      delim_q  <= DELIM_RST;
      dcount_q <= DCOUNT_RST;
      tbase_q  <= TBASE_RST;
      tper_q   <= TPERBYTE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_HDR_LO:   hdr_lo_q <= cfg_data_i;
        CFG_HDR_HI:   hdr_hi_q <= cfg_data_i[7:0];
        CFG_DELIM:    delim_q  <= cfg_data_i[31:0];
        CFG_DCOUNT:   dcount_q <= cfg_data_i[2:0];
        CFG_TBASE:    tbase_q  <= cfg_data_i[15:0];
        CFG_TPERBYTE: tper_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Frame buffer
  sfe_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_BYTES)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_byte),
    .waddr_i (fill_q),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // Pattern bytes, byte 0 in the low bits of the low register
  always_comb begin
    for (int i = 0; i < PAT_BYTES - 1; i++) begin
      pat[i] = hdr_lo_q[8*i +: 8];
    end
    pat[PAT_BYTES-1] = hdr_hi_q;
  end

  // Header check over the last HEADER_BYTES bytes; hist_q[0] is the newest
  always_comb begin
    hdr_match = (hist_q[HEADER_BYTES-1] == pat[0]) &&
                (hist_q[0] == pat[HEADER_BYTES-1]);
    hdr_len   = '0;
    for (int i = 1; i < HEADER_BYTES - 1; i++) begin
      if (pat[i] == NIBBLE_MARK) begin
        if (hist_q[HEADER_BYTES-1-i] > NIBBLE_MARK) begin
          hdr_match = 1'b0;
        end
        hdr_len = {hdr_len[11:0], hist_q[HEADER_BYTES-1-i][3:0]};
      end else if (pat[i] != hist_q[HEADER_BYTES-1-i]) begin
        hdr_match = 1'b0;
      end
    end
  end

  assign hdr_valid = (fill_q >= AW'(HEADER_BYTES)) && hdr_match && (hdr_len != 16'd0);
  assign hdr_fits  = hdr_len < 16'(BUFFER_BYTES);

  // Delimiter check; out-of-range counts are clamped to 1..4
  always_comb begin
    if (dcount_q == 3'd0) begin
      dc = 3'd1;
    end else if (dcount_q > 3'(DELIM_MAX)) begin
      dc = 3'(DELIM_MAX);
    end else begin
      dc = dcount_q;
    end
    for (int i = 0; i < DELIM_MAX; i++) begin
      tail[i] = hist_q[i];
    end
    delim_match = 1'b1;
    didx        = '0;
    for (int i = 0; i < DELIM_MAX; i++) begin
      if (3'(i) < dc) begin
        didx = 2'(dc - 3'(i) - 3'd1);
        if (tail[didx] != delim_q[8*i +: 8]) begin
          delim_match = 1'b0;
        end
      end
    end
  end

  assign delim_hit = (fill_q >= AW'(dc)) && delim_match;
  assign start     = fill_q - AW'(dc);

  // Frame control next state
  assign fill_inc    = (fill_q == AW'(BUFFER_BYTES - 1)) ? '0 : fill_q + AW'(1);
  assign elapsed_inc = elapsed_q + TICK_W'(1);
  assign limit       = TICK_W'(prod_q) + TICK_W'(tbase_q);

  always_comb begin
    fill_d    = fill_q;
    exp_d     = exp_q;
    elapsed_d = elapsed_q;
    if (cmd_i.wr_byte) begin
      fill_d = fill_inc;
    end
    if (cmd_i.hdr_take) begin
      fill_d = '0;
      if (hdr_fits) begin
        exp_d     = hdr_len[AW-1:0];
        elapsed_d = '0;
      end
    end
    if (cmd_i.cnt_emit) begin
      fill_d    = '0;
      exp_d     = '0;
      elapsed_d = '0;
    end
    if (cmd_i.dlm_emit) begin
      fill_d = '0;
    end
    // Timeout drops the partial frame without a result
    if (cmd_i.tick_upd) begin
      if (elapsed_inc > limit) begin
        fill_d    = '0;
        exp_d     = '0;
        elapsed_d = '0;
      end else begin
        elapsed_d = elapsed_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      exp_q     <= '0;
      elapsed_q <= '0;
    end else begin
      fill_q    <= fill_d;
      exp_q     <= exp_d;
      elapsed_q <= elapsed_d;
    end
  end

  // Byte history, newest at index 0
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_byte) begin
      hist_q[0] <= rx_byte_i;
      for (int k = 1; k < HIST_BYTES; k++) begin
        hist_q[k] <= hist_q[k-1];
      end
    end
  end

  // Timeout product
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_mul) begin
      prod_q <= PW'(exp_q) * PW'(tper_q);
    end
  end

  // Readout counters and result register
  assign rd_last = (rd_idx_q + AW'(1)) == count_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_emit) begin
      count_q  <= fill_q;
      by_len_q <= 1'b1;
      rd_idx_q <= '0;
    end else if (cmd_i.dlm_emit) begin
      count_q  <= start;
      by_len_q <= 1'b0;
      rd_idx_q <= '0;
    end else if (cmd_i.rd_next) begin
      rd_idx_q <= rd_idx_q + AW'(1);
    end
    if (cmd_i.emit_empty) begin
      out_q.frame_byte       <= '0;
      out_q.last             <= 1'b1;
      out_q.framed_by_length <= 1'b0;
      out_q.empty_frame      <= 1'b1;
    end else if (cmd_i.out_load) begin
      out_q.frame_byte       <= ram_rdata;
      out_q.last             <= rd_last;
      out_q.framed_by_length <= by_len_q;
      out_q.empty_frame      <= 1'b0;
    end
  end

  assign out_o = out_q;

  // Status towards the controller
  assign status_o.counted     = exp_q != '0;
  assign status_o.fill_eq_exp = fill_q == exp_q;
  assign status_o.hdr_valid   = hdr_valid;
  assign status_o.delim_hit   = delim_hit;
  assign status_o.delim_empty = start == '0;
  assign status_o.out_last    = out_q.last;

endmodule

FILE: rtl/sfe_ctrl.sv
// Controller of the serial frame extractor: sequences bytes, ticks and frame readout.
module sfe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_op_i,
  input  logic                out_stall_i,
  input  sfe_pkg::dp_status_t status_i,
  output sfe_pkg::dp_cmd_t    cmd_o,
  output logic                in_stall_o,
  output logic                out_valid_o
);
  import sfe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BYTE,
    S_TICK_UPD,
    S_EMIT_RD,
    S_EMIT_LD,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   in_stall_q;
  logic   out_valid_q;

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i == OP_BYTE) begin
            cmd_o.wr_byte = 1'b1;
            state_d       = S_BYTE;
          end else if (status_i.counted) begin
            cmd_o.tick_mul = 1'b1;
            state_d        = S_TICK_UPD;
          end
        end
      end
      S_BYTE: begin
        state_d = S_IDLE;
        if (status_i.counted) begin
          if (status_i.fill_eq_exp) begin
            cmd_o.cnt_emit = 1'b1;
            state_d        = S_EMIT_RD;
          end
        end else if (status_i.hdr_valid) begin
          cmd_o.hdr_take = 1'b1;
        end else if (status_i.delim_hit) begin
          cmd_o.dlm_emit = 1'b1;
          if (status_i.delim_empty) begin
            cmd_o.emit_empty = 1'b1;
            state_d          = S_OUT;
          end else begin
            state_d = S_EMIT_RD;
          end
        end
      end
      S_TICK_UPD: begin
        cmd_o.tick_upd = 1'b1;
        state_d        = S_IDLE;
      end
      S_EMIT_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd_o.out_load = 1'b1;
        state_d        = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          if (status_i.out_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_next = 1'b1;
            state_d       = S_EMIT_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_stall_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_stall_q  <= state_d != S_IDLE;
      out_valid_q <= state_d == S_OUT;
    end
  end

  assign in_stall_o  = in_stall_q;
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/serial_frame_extractor.sv
// Top level of the serial frame extractor.
`include "serial_frame_extractor_assert.svh"

// Splits received serial bytes into frames, either by a length header matched against
// the header pattern (counted mode, with a tick timeout) or by a trailing delimiter.
// A received byte is first stored and then checked against header and delimiter. A
// tick in counted mode is handled by a multiply and then an add and compare; outside
// counted mode it changes nothing. When a frame completes, it is read out of the
// single-port-read buffer RAM byte by byte (read, register, hand over), waiting while
// the output is stalled; the input is held off until the last byte is handed over.
// An empty delimiter frame gives one result with empty_frame set. Configuration
// writes are always taken and must only be made while the block is idle.
module serial_frame_extractor #(
  parameter int BUFFER_BYTES = 64,
  parameter int HEADER_BYTES = 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sfe_pkg::in_item_t  in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sfe_pkg::out_item_t out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);
  import sfe_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  // Controller
  sfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_i.op),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  // Datapath
  sfe_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rx_byte_i   (in_i.rx_byte),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_o       (out_o)
  );

  // A stored byte is always checked before the next transaction is taken
  `SFE_ASSERT_NEXT(a_byte_then_busy, in_valid_i && !in_stall_o && (in_i.op == OP_BYTE), in_stall_o)
  // Input is held off for the whole readout
  `SFE_ASSERT_IMPLIES(a_out_blocks_in, out_valid_o, in_stall_o)
  // An empty frame is a single delimiter result
  `SFE_ASSERT_IMPLIES(a_empty_is_last, out_valid_o && out_o.empty_frame, out_o.last && !out_o.framed_by_length)
  // Handing over the last byte ends the readout
  `SFE_ASSERT_NEXT(a_last_ends_frame, out_valid_o && !out_stall_i && out_o.last, !out_valid_o)

endmodule
